[sv/kle_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package kle_pkg;

  typedef enum logic [1:0] {
    FUNC_LOAD_KEY    = 2'd0,
    FUNC_LOAD_PERIOD = 2'd1,
    FUNC_STEP        = 2'd2,
    FUNC_CLEAR       = 2'd3
  } func_e;

  localparam int unsigned CFG_OBJECT_ID   = 0;
  localparam int unsigned CFG_TIMER_START = 1;
  localparam int unsigned CfgIdxW         = 1;

  localparam int unsigned TimeW = 32;
  localparam int unsigned PosW  = 32;
  localparam int unsigned ObjW  = 16;
  localparam int unsigned FracW = 16;

  // controller -> datapath commands
  typedef struct packed {
    logic load_item;    // capture input item and apply step to timer
    logic clear;        // empty both tables and reload timer
    logic per_rd;       // issue period read at scan index
    logic per_chk;      // check returned period entry
    logic key_rd;       // issue keyframe time read at scan index
    logic key_chk;      // compare returned keyframe time
    logic scan_rst;     // reset scan index
    logic scan_inc;     // advance scan index
    logic pos1_rd;      // read position of lower keyframe
    logic pos2_rd;      // read position of upper keyframe
    logic pos_cap1;     // capture lower position
    logic pos_cap2;     // capture upper position
    logic div_start;
    logic div_step;
    logic mul_axis;     // multiply one axis
    logic res_load;     // load output register
  } cmd_t;

  typedef struct packed {
    logic per_done;     // scan index reached period count
    logic key_done;     // scan index reached key count
    logic in_period;
    logic bracket;
    logic div_done;
    logic axis_done;
  } sts_t;

endpackage
`default_nettype wire

[sv/kle_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module kle_datapath #(
  parameter int unsigned MaxKeys    = 64,
  parameter int unsigned MaxPeriods = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  kle_pkg::cmd_t          cmd_i,
  output kle_pkg::sts_t                sts_o,
  input  wire  [1:0]                   func_i,
  input  wire  [kle_pkg::TimeW-1:0]    time_value_i,
  input  wire  [kle_pkg::TimeW-1:0]    time_end_i,
  input  wire  [kle_pkg::PosW-1:0]     pos_x_i,
  input  wire  [kle_pkg::PosW-1:0]     pos_y_i,
  input  wire  [kle_pkg::PosW-1:0]     pos_z_i,
  input  wire  [kle_pkg::TimeW-1:0]    timer_start_i,
  output logic [3*kle_pkg::PosW-1:0]   res_pos_o,
  output logic                         res_ok_o
);
  import kle_pkg::*;

  localparam int unsigned KeyIdxW = (MaxKeys > 1) ? $clog2(MaxKeys) : 1;
  localparam int unsigned PerIdxW = (MaxPeriods > 1) ? $clog2(MaxPeriods) : 1;
  localparam int unsigned KeyCntW = $clog2(MaxKeys + 1);
  localparam int unsigned PerCntW = $clog2(MaxPeriods + 1);
  localparam int unsigned ScanW   = (KeyCntW > PerCntW) ? KeyCntW : PerCntW;
  localparam int unsigned NumW    = TimeW + FracW;

  logic [TimeW-1:0]  key_time_mem [MaxKeys];
  logic [3*PosW-1:0] key_pos_mem  [MaxKeys];
  logic [TimeW-1:0]  per_start_mem [MaxPeriods];
  logic [TimeW-1:0]  per_end_mem   [MaxPeriods];

  logic [KeyCntW-1:0] key_count_q;
  logic [PerCntW-1:0] per_count_q;
  logic [TimeW-1:0]   timer_q;
  logic [ScanW-1:0]   scan_q, chk_idx_q;

  logic [TimeW-1:0]  kt_rd_q, ps_rd_q, pe_rd_q;
  logic [3*PosW-1:0] pos_rd_q, p1_q, p2_q;

  logic              inside_q, have1_q, have2_q;
  logic [KeyIdxW-1:0] i1_q, i2_q;
  logic [TimeW-1:0]  t1_q, t2_q;

  logic              is_key, is_per;
  logic [TimeW:0]    sum;

  assign is_key = cmd_i.load_item && (func_i == FUNC_LOAD_KEY) &&
                  (key_count_q < KeyCntW'(MaxKeys));
  assign is_per = cmd_i.load_item && (func_i == FUNC_LOAD_PERIOD) &&
                  (per_count_q < PerCntW'(MaxPeriods));
  assign sum = {1'b0, timer_q} + {1'b0, time_value_i};

  // memories
  always_ff @(posedge clk_i) begin
    if (is_key) begin
      key_time_mem[key_count_q[KeyIdxW-1:0]] <= time_value_i;
      key_pos_mem[key_count_q[KeyIdxW-1:0]]  <= {pos_z_i, pos_y_i, pos_x_i};
    end
    if (cmd_i.key_rd) kt_rd_q <= key_time_mem[scan_q[KeyIdxW-1:0]];
    if (cmd_i.pos1_rd) pos_rd_q <= key_pos_mem[i1_q];
    else if (cmd_i.pos2_rd) pos_rd_q <= key_pos_mem[i2_q];
  end

  always_ff @(posedge clk_i) begin
    if (is_per) begin
      per_start_mem[per_count_q[PerIdxW-1:0]] <= time_value_i;
      per_end_mem[per_count_q[PerIdxW-1:0]]   <= time_end_i;
    end
    if (cmd_i.per_rd) begin
      ps_rd_q <= per_start_mem[scan_q[PerIdxW-1:0]];
      pe_rd_q <= per_end_mem[scan_q[PerIdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
      per_count_q <= '0;
      timer_q     <= '0;
      scan_q      <= '0;
      chk_idx_q   <= '0;
    end else begin
      if (is_key) key_count_q <= key_count_q + 1'b1;
      if (is_per) per_count_q <= per_count_q + 1'b1;
      if (cmd_i.load_item && func_i == FUNC_STEP)
        timer_q <= sum[TimeW] ? '1 : sum[TimeW-1:0];
      if (cmd_i.clear) begin
        key_count_q <= '0;
        per_count_q <= '0;
        timer_q     <= timer_start_i;
      end
      if (cmd_i.scan_rst) scan_q <= '0;
      else if (cmd_i.scan_inc) scan_q <= scan_q + 1'b1;
      chk_idx_q <= scan_q;
    end
  end

  // scan comparisons and position captures
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rst && !cmd_i.key_chk) begin
      if (cmd_i.per_chk == 1'b0 && cmd_i.key_rd == 1'b0) inside_q <= 1'b0;
      if (cmd_i.key_rd == 1'b1) begin
        have1_q <= 1'b0;
        have2_q <= 1'b0;
      end
    end
    if (cmd_i.per_chk && timer_q > ps_rd_q && timer_q < pe_rd_q) inside_q <= 1'b1;
    if (cmd_i.key_chk) begin
      if (kt_rd_q < timer_q && (!have1_q || kt_rd_q > t1_q)) begin
        have1_q <= 1'b1;
        t1_q    <= kt_rd_q;
        i1_q    <= chk_idx_q[KeyIdxW-1:0];
      end
      if (kt_rd_q > timer_q && (!have2_q || kt_rd_q < t2_q)) begin
        have2_q <= 1'b1;
        t2_q    <= kt_rd_q;
        i2_q    <= chk_idx_q[KeyIdxW-1:0];
      end
    end
    if (cmd_i.pos_cap1) p1_q <= pos_rd_q;
    if (cmd_i.pos_cap2) p2_q <= pos_rd_q;
  end

  // restoring divider, one quotient bit a cycle
  logic [NumW-1:0]    num_q;
  logic [TimeW:0]     rem_q;
  logic [TimeW-1:0]   den_q;
  logic [FracW-1:0]   frac_q;
  logic [5:0]         div_cnt_q;
  logic [TimeW+1:0]   trial;
  logic [TimeW:0]     shifted;

  assign shifted = {rem_q[TimeW-1:0], num_q[NumW-1]};
  assign trial   = {1'b0, shifted} - {2'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      num_q     <= {timer_q - t1_q, {FracW{1'b0}}};
      den_q     <= t2_q - t1_q;
      rem_q     <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[NumW-2:0], 1'b0};
      if (!trial[TimeW+1]) begin
        rem_q <= trial[TimeW:0];
        frac_q <= {frac_q[FracW-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        frac_q <= {frac_q[FracW-2:0], 1'b0};
      end
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  // one axis per cycle through a shared 33x17 multiplier, registered, then floored
  logic [1:0]              axis_q;
  logic                    prod_v_q;
  logic signed [PosW:0]    diff;
  logic signed [PosW+FracW+1:0] prod_q;
  logic [1:0]              prod_axis_q;
  logic signed [PosW+FracW+1:0] prod_adj;
  logic signed [PosW:0]    d_axis;
  logic signed [PosW-1:0]  p1_sel;

  always_comb begin
    case (axis_q)
      2'd0:    diff = $signed({p2_q[PosW-1],       p2_q[PosW-1:0]})
                    - $signed({p1_q[PosW-1],       p1_q[PosW-1:0]});
      2'd1:    diff = $signed({p2_q[2*PosW-1],     p2_q[2*PosW-1:PosW]})
                    - $signed({p1_q[2*PosW-1],     p1_q[2*PosW-1:PosW]});
      default: diff = $signed({p2_q[3*PosW-1],     p2_q[3*PosW-1:2*PosW]})
                    - $signed({p1_q[3*PosW-1],     p1_q[3*PosW-1:2*PosW]});
    endcase
    case (prod_axis_q)
      2'd0:    p1_sel = $signed(p1_q[PosW-1:0]);
      2'd1:    p1_sel = $signed(p1_q[2*PosW-1:PosW]);
      default: p1_sel = $signed(p1_q[3*PosW-1:2*PosW]);
    endcase
    // arithmetic shift floors toward minus infinity
    prod_adj = prod_q >>> FracW;
    d_axis   = prod_adj[PosW:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q   <= '0;
      prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= cmd_i.mul_axis && (axis_q != 2'd3);
      if (cmd_i.div_start) axis_q <= '0;
      else if (cmd_i.mul_axis && axis_q != 2'd3) axis_q <= axis_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_axis && axis_q != 2'd3) begin
      prod_q      <= diff * $signed({1'b0, frac_q});
      prod_axis_q <= axis_q;
    end
    if (prod_v_q) begin
      case (prod_axis_q)
        2'd0:    res_pos_o[PosW-1:0]        <= PosW'(p1_sel + d_axis[PosW-1:0]);
        2'd1:    res_pos_o[2*PosW-1:PosW]   <= PosW'(p1_sel + d_axis[PosW-1:0]);
        default: res_pos_o[3*PosW-1:2*PosW] <= PosW'(p1_sel + d_axis[PosW-1:0]);
      endcase
    end
    if (cmd_i.res_load && !(have1_q && have2_q)) res_pos_o <= '0;
    if (cmd_i.res_load) res_ok_o <= have1_q && have2_q;
  end

  assign sts_o.per_done  = (scan_q >= ScanW'(per_count_q));
  assign sts_o.key_done  = (scan_q >= ScanW'(key_count_q));
  assign sts_o.in_period = inside_q;
  assign sts_o.bracket   = have1_q && have2_q;
  assign sts_o.div_done  = (div_cnt_q == 6'(NumW));
  assign sts_o.axis_done = (axis_q == 2'd3) && !prod_v_q;

endmodule
`default_nettype wire

[sv/kle_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module kle_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  wire  [1:0]          func_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output kle_pkg::cmd_t       cmd_o,
  input  wire  kle_pkg::sts_t sts_i
);
  import kle_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_PSCAN  = 11'b00000000010,
    S_PLAST  = 11'b00000000100,
    S_KSCAN  = 11'b00000001000,
    S_KLAST  = 11'b00000010000,
    S_POS1   = 11'b00000100000,
    S_POS2   = 11'b00001000000,
    S_DIV    = 11'b00010000000,
    S_MUL    = 11'b00100000000,
    S_RES    = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   pchk_q, pchk_d, kchk_q, kchk_d;
  logic   [1:0] pos_ph_q, pos_ph_d;

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pchk_d      = 1'b0;
    kchk_d      = 1'b0;
    pos_ph_d    = pos_ph_q;
    cmd_o       = '0;
    cmd_o.per_chk = pchk_q;
    cmd_o.key_chk = kchk_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load_item = 1'b1;
          cmd_o.clear     = (func_i == FUNC_CLEAR);
          if (func_i == FUNC_STEP) begin
            cmd_o.scan_rst = 1'b1;
            state_d = S_PSCAN;
          end
        end
      end
      S_PSCAN: begin
        if (sts_i.per_done) state_d = S_PLAST;
        else begin
          cmd_o.per_rd   = 1'b1;
          cmd_o.scan_inc = 1'b1;
          pchk_d         = 1'b1;
        end
      end
      S_PLAST: begin
        // wait for the last check to settle
        if (!pchk_q) begin
          if (sts_i.in_period) begin
            cmd_o.scan_rst = 1'b1;
            cmd_o.key_rd   = 1'b1;
            state_d        = S_KSCAN;
          end else state_d = S_IDLE;
        end
      end
      S_KSCAN: begin
        if (sts_i.key_done) state_d = S_KLAST;
        else begin
          cmd_o.key_rd   = 1'b1;
          cmd_o.scan_inc = 1'b1;
          kchk_d         = 1'b1;
        end
      end
      S_KLAST: begin
        if (!kchk_q) begin
          if (sts_i.bracket) begin
            pos_ph_d = '0;
            state_d  = S_POS1;
          end else state_d = S_RES;
        end
      end
      S_POS1: begin
        pos_ph_d = pos_ph_q + 1'b1;
        case (pos_ph_q)
          2'd0: cmd_o.pos1_rd = 1'b1;
          2'd1: begin
            cmd_o.pos_cap1 = 1'b1;
            cmd_o.pos2_rd  = 1'b1;
            state_d        = S_POS2;
          end
          default: ;
        endcase
      end
      S_POS2: begin
        cmd_o.pos_cap2  = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) state_d = S_MUL;
        else cmd_o.div_step = 1'b1;
      end
      S_MUL: begin
        cmd_o.mul_axis = 1'b1;
        if (sts_i.axis_done) state_d = S_RES;
      end
      S_RES: begin
        cmd_o.res_load = 1'b1;
        out_valid_d    = 1'b1;
        state_d        = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pchk_q      <= 1'b0;
      kchk_q      <= 1'b0;
      pos_ph_q    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pchk_q      <= pchk_d;
      kchk_q      <= kchk_d;
      pos_ph_q    <= pos_ph_d;
    end
  end

endmodule
`default_nettype wire

[sv/keyframe_lerp_engine.sv]
// Keyframe animation channel with linear interpolation.
// Input stream s_axis_*: one item per handshake; tuser carries func
// (0 load keyframe, 1 load period, 2 step, 3 clear), tdata carries
// time_value, time_end, pos_x, pos_y, pos_z from the lowest bit up.
// Output stream m_axis_*: one item per step whose timer lies strictly inside
// a period; tdata carries out_object, out_x, out_y, out_z, tuser bracket_ok.
// Configuration: cfg_we_i writes register cfg_idx_i (0 object id,
// 1 timer start) with cfg_wdata_i; write only while the block is idle.
// Loads and clears are applied at their handshake. A step scans the period table
// then the keyframe table, one entry a cycle through each table's read port,
// then runs a bit-serial divider and three registered multiplies. Without
// both neighbours the divider and multiplies are skipped; a step outside every
// period skips the keyframe scan and gives no result. The next item is taken
// in the cycle after the result handshake: one item at a time.
// Reset empties both tables and clears the timer; no clearing pass is run.
// While the receiver stalls, the result is held and no item is accepted.
`timescale 1ns / 1ps
`default_nettype none
module keyframe_lerp_engine #(
  parameter int unsigned MAX_KEYFRAMES = 64,
  parameter int unsigned MAX_PERIODS   = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // time_value[31:0], time_end[63:32], pos_x[95:64], pos_y[127:96], pos_z[159:128]
  input  wire  [159:0] s_axis_tdata,
  // func[1:0]
  input  wire  [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // out_object[15:0], out_x[47:16], out_y[79:48], out_z[111:80]
  output logic [111:0] m_axis_tdata,
  // bracket_ok[0]
  output logic [0:0]   m_axis_tuser,
  input  wire          cfg_we_i,
  input  wire  [kle_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire  [31:0]  cfg_wdata_i
);
  import kle_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [ObjW-1:0]   object_id_q;
  logic [TimeW-1:0]  timer_start_q;
  logic [3*PosW-1:0] res_pos;
  logic              res_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      object_id_q   <= '0;
      timer_start_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIdxW'(CFG_OBJECT_ID):   object_id_q   <= cfg_wdata_i[ObjW-1:0];
        CfgIdxW'(CFG_TIMER_START): timer_start_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  kle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .func_i      (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  kle_datapath #(
    .MaxKeys    (MAX_KEYFRAMES),
    .MaxPeriods (MAX_PERIODS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .func_i        (s_axis_tuser),
    .time_value_i  (s_axis_tdata[31:0]),
    .time_end_i    (s_axis_tdata[63:32]),
    .pos_x_i       (s_axis_tdata[95:64]),
    .pos_y_i       (s_axis_tdata[127:96]),
    .pos_z_i       (s_axis_tdata[159:128]),
    .timer_start_i (timer_start_q),
    .res_pos_o     (res_pos),
    .res_ok_o      (res_ok)
  );

  assign m_axis_tdata = {res_pos, object_id_q};
  assign m_axis_tuser = res_ok;

endmodule
`default_nettype wire
